// ===== sv/input_latency_monitor_macros.svh =====
// assertion macros for the input latency monitor
// used by the top level only; needs clk and rst_n in the including scope
`ifndef INPUT_LATENCY_MONITOR_MACROS_SVH
`define INPUT_LATENCY_MONITOR_MACROS_SVH

// same-cycle implication, off during reset
`define ILM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ILM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ilm_pkg.sv =====
// shared constants, opcodes and controller/datapath command types
// for the input latency monitor; no dependencies
package ilm_pkg;

  localparam int NUM_PORTS  = 4;
  localparam int PORT_IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int DATA_W     = 64;
  localparam int PORT_W     = 5;
  localparam int OP_W       = 2;

  localparam logic [OP_W-1:0] OP_STAMP_ONE = 2'd0;
  localparam logic [OP_W-1:0] OP_STAMP_ALL = 2'd1;
  localparam logic [OP_W-1:0] OP_POLL      = 2'd2;
  localparam logic [OP_W-1:0] OP_REPORT    = 2'd3;

  typedef struct packed {
    logic latch;        // capture the input word
    logic stamp_one;    // write one port's stamp (if port valid)
    logic stamp_all;    // write every stamp
    logic count_update;
    logic count_poll;
    logic calc_delta;   // compute now - stamp and its hit flag
    logic fold;         // fold delta into total and peak
    logic report;       // clear the counters
    logic load_out;     // copy the counters into the output register
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            any_nonzero;
  } status_t;

endpackage

// ===== sv/input_latency_monitor.sv =====
// sequence: stamp and report words pass capture and execute, a poll passes
// capture, delta and fold; a report word appears on the output in the cycle
// after its execute step; no new word is taken until the last one is done, and
// a report waits in execute while the output register holds an untaken word
// reset: synchronous active-low rst_n clears the stamps, counters and
// output valid
module input_latency_monitor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ilm_pkg::OP_W-1:0]          in_opcode,
  input  logic [ilm_pkg::PORT_W-1:0]        in_port,
  input  logic signed [ilm_pkg::DATA_W-1:0] in_time_us,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ilm_pkg::DATA_W-1:0]        out_poll_count,
  output logic [ilm_pkg::DATA_W-1:0]        out_update_count,
  output logic [ilm_pkg::DATA_W-1:0]        out_latency_total,
  output logic [ilm_pkg::DATA_W-1:0]        out_latency_max
);
  import ilm_pkg::*;

  cmd_t    cmd;
  status_t status;

  ilm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ilm_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_opcode         (in_opcode),
    .in_port           (in_port),
    .in_time_us        (in_time_us),
    .out_poll_count    (out_poll_count),
    .out_update_count  (out_update_count),
    .out_latency_total (out_latency_total),
    .out_latency_max   (out_latency_max)
  );

`include "input_latency_monitor_macros.svh"

  `ILM_ASSERT_NOW(a_no_zero_report, $rose(out_valid), (out_poll_count != '0) || (out_update_count != '0) || (out_latency_total != '0) || (out_latency_max != '0), "report word with all counters zero")
  `ILM_ASSERT_NOW(a_out_from_load, $rose(out_valid), $past(cmd.load_out), "output valid without a load")
  `ILM_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second word taken while one is in flight")

endmodule

// ===== sv/ilm_datapath.sv =====
// datapath: input word register, port stamps, counters, delta stage
// and output register; depends on ilm_pkg
module ilm_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ilm_pkg::cmd_t               cmd,
  output ilm_pkg::status_t            status,
  input  logic [ilm_pkg::OP_W-1:0]    in_opcode,
  input  logic [ilm_pkg::PORT_W-1:0]  in_port,
  input  logic signed [ilm_pkg::DATA_W-1:0] in_time_us,
  output logic [ilm_pkg::DATA_W-1:0]  out_poll_count,
  output logic [ilm_pkg::DATA_W-1:0]  out_update_count,
  output logic [ilm_pkg::DATA_W-1:0]  out_latency_total,
  output logic [ilm_pkg::DATA_W-1:0]  out_latency_max
);
  import ilm_pkg::*;

  logic [OP_W-1:0]   op_r;
  logic [PORT_W-1:0] port_r;
  logic [DATA_W-1:0] time_r;

  logic [DATA_W-1:0] stamp_r [NUM_PORTS];
  logic [DATA_W-1:0] polls_r, updates_r, sum_r, peak_r;
  logic [DATA_W-1:0] delta_r;
  logic              hit_r;

  logic [DATA_W-1:0] out_polls_r, out_updates_r, out_sum_r, out_peak_r;

  logic                  port_ok;
  logic [PORT_IDX_W-1:0] idx;
  logic [DATA_W-1:0]     stamp_rd;
  logic                  hit_nxt;

  assign port_ok  = port_r < PORT_W'(NUM_PORTS);
  assign idx      = port_r[PORT_IDX_W-1:0];
  assign stamp_rd = stamp_r[idx];
  // a zero stamp means never stamped; a clock going backwards adds nothing
  assign hit_nxt  = port_ok && (stamp_rd != '0) &&
                    !($signed(time_r) < $signed(stamp_rd));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_opcode;
      port_r <= in_port;
      time_r <= in_time_us;
    end
    if (cmd.calc_delta) begin
      delta_r <= time_r - stamp_rd;
    end
    if (cmd.load_out) begin
      out_polls_r   <= polls_r;
      out_updates_r <= updates_r;
      out_sum_r     <= sum_r;
      out_peak_r    <= peak_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        stamp_r[i] <= '0;
      end
      polls_r   <= '0;
      updates_r <= '0;
      sum_r     <= '0;
      peak_r    <= '0;
      hit_r     <= 1'b0;
    end else begin
      if (cmd.stamp_all) begin
        for (int i = 0; i < NUM_PORTS; i++) begin
          stamp_r[i] <= time_r;
        end
      end else if (cmd.stamp_one && port_ok) begin
        stamp_r[idx] <= time_r;
      end
      if (cmd.calc_delta) begin
        hit_r <= hit_nxt;
      end
      if (cmd.report) begin
        polls_r   <= '0;
        updates_r <= '0;
        sum_r     <= '0;
        peak_r    <= '0;
      end else begin
        if (cmd.count_update) begin
          updates_r <= updates_r + DATA_W'(1);
        end
        if (cmd.count_poll) begin
          polls_r <= polls_r + DATA_W'(1);
        end
        if (cmd.fold && hit_r) begin
          sum_r <= sum_r + delta_r;
          if (delta_r > peak_r) begin
            peak_r <= delta_r;
          end
        end
      end
    end
  end

  assign status.op          = op_r;
  assign status.any_nonzero = |(polls_r | updates_r | sum_r | peak_r);

  assign out_poll_count    = out_polls_r;
  assign out_update_count  = out_updates_r;
  assign out_latency_total = out_sum_r;
  assign out_latency_max   = out_peak_r;

endmodule

// ===== sv/ilm_ctrl.sv =====
// controller: sequences each word through capture and execute (a poll also
// through fold), owns the handshakes; depends on ilm_pkg
module ilm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ilm_pkg::status_t  status,
  output ilm_pkg::cmd_t     cmd
);
  import ilm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_FOLD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (status.op)
          OP_STAMP_ONE: begin
            cmd.stamp_one    = 1'b1;
            cmd.count_update = 1'b1;
            state_nxt        = ST_IDLE;
          end
          OP_STAMP_ALL: begin
            cmd.stamp_all    = 1'b1;
            cmd.count_update = 1'b1;
            state_nxt        = ST_IDLE;
          end
          OP_POLL: begin
            cmd.count_poll = 1'b1;
            cmd.calc_delta = 1'b1;
            state_nxt      = ST_FOLD;
          end
          OP_REPORT: begin
            // hold until the output register can take a new word
            if (out_free) begin
              cmd.report   = 1'b1;
              cmd.load_out = status.any_nonzero;
              state_nxt    = ST_IDLE;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;

endmodule

// ===== sim/latency_report_checker.sv =====
// checker for the input latency monitor: follows both channels, keeps its own
// copy of the stamps and counters, and compares every report word it sees
// depends on ilm_pkg for the opcodes, widths and port count
`timescale 1ns / 1ps

module latency_report_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [ilm_pkg::OP_W-1:0]          in_opcode,
  input  logic [ilm_pkg::PORT_W-1:0]        in_port,
  input  logic signed [ilm_pkg::DATA_W-1:0] in_time_us,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [ilm_pkg::DATA_W-1:0]        out_poll_count,
  input  logic [ilm_pkg::DATA_W-1:0]        out_update_count,
  input  logic [ilm_pkg::DATA_W-1:0]        out_latency_total,
  input  logic [ilm_pkg::DATA_W-1:0]        out_latency_max,
  output int                                mismatch_count,
  output int                                reports_pending,
  output int                                reports_checked
);
  import ilm_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] polls;
    logic [DATA_W-1:0] updates;
    logic [DATA_W-1:0] total;
    logic [DATA_W-1:0] peak;
  } report_t;

  logic [DATA_W-1:0] stamp_q [NUM_PORTS];
  logic [DATA_W-1:0] polls_seen;
  logic [DATA_W-1:0] updates_seen;
  logic [DATA_W-1:0] latency_sum;
  logic [DATA_W-1:0] latency_peak;
  report_t           expected_reports [$];

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  // applies one accepted word to the shadow state
  task automatic fold_word(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                           input logic [DATA_W-1:0] now);
    logic [DATA_W-1:0] last;
    logic [DATA_W-1:0] delta;
    report_t           rep;
    case (op)
      OP_STAMP_ONE: begin
        if (port < NUM_PORTS) stamp_q[int'(port)] = now;
        updates_seen++;
      end
      OP_STAMP_ALL: begin
        for (int p = 0; p < NUM_PORTS; p++) stamp_q[p] = now;
        updates_seen++;
      end
      OP_POLL: begin
        polls_seen++;
        if (port < NUM_PORTS) begin
          last = stamp_q[int'(port)];
          // zero stamp means never updated; clock going backwards is skipped
          if (last != '0 && !($signed(now) < $signed(last))) begin
            delta = now - last;
            latency_sum = latency_sum + delta;
            if (delta > latency_peak) latency_peak = delta;
          end
        end
      end
      default: begin
        rep = '{polls_seen, updates_seen, latency_sum, latency_peak};
        if (rep != '0) expected_reports.push_back(rep);
        polls_seen   = '0;
        updates_seen = '0;
        latency_sum  = '0;
        latency_peak = '0;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PORTS; p++) stamp_q[p] = '0;
      polls_seen   = '0;
      updates_seen = '0;
      latency_sum  = '0;
      latency_peak = '0;
      expected_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          note_mismatch("report word with nothing expected");
        end else begin
          compare_field("poll_count", out_poll_count, expected_reports[0].polls);
          compare_field("update_count", out_update_count, expected_reports[0].updates);
          compare_field("latency_total", out_latency_total, expected_reports[0].total);
          compare_field("latency_max", out_latency_max, expected_reports[0].peak);
          void'(expected_reports.pop_front());
          reports_checked++;
        end
      end
      if (in_valid && !in_stall) fold_word(in_opcode, in_port, in_time_us);
    end
    reports_pending = expected_reports.size();
  end

endmodule

// ===== sim/input_latency_monitor_tb.sv =====
// top of the input latency monitor testbench: clock, reset, word stimulus,
// output stall pattern, idle watchdog and verdict
// depends on ilm_pkg, input_latency_monitor and latency_report_checker
`timescale 1ns / 1ps

module input_latency_monitor_tb;
  import ilm_pkg::*;

  localparam int RANDOM_WORDS = 1000;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 12;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
  } stall_mode_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [OP_W-1:0]           in_opcode = OP_STAMP_ONE;
  logic [PORT_W-1:0]         in_port = '0;
  logic signed [DATA_W-1:0]  in_time_us = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [DATA_W-1:0]         out_poll_count;
  logic [DATA_W-1:0]         out_update_count;
  logic [DATA_W-1:0]         out_latency_total;
  logic [DATA_W-1:0]         out_latency_max;

  int          mismatch_count;
  int          reports_pending;
  int          reports_checked;
  int          words_sent = 0;
  int          op_words [4] = '{0, 0, 0, 0};
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic [DATA_W-1:0] now_us = 64'd1;
  logic [5:0]  stall_phase;
  stall_mode_t stall_mode;

  input_latency_monitor dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_port           (in_port),
    .in_time_us        (in_time_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_poll_count    (out_poll_count),
    .out_update_count  (out_update_count),
    .out_latency_total (out_latency_total),
    .out_latency_max   (out_latency_max)
  );

  latency_report_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_port           (in_port),
    .in_time_us        (in_time_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_poll_count    (out_poll_count),
    .out_update_count  (out_update_count),
    .out_latency_total (out_latency_total),
    .out_latency_max   (out_latency_max),
    .mismatch_count    (mismatch_count),
    .reports_pending   (reports_pending),
    .reports_checked   (reports_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall: a new mode each time the 6-bit phase counter wraps
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_phase <= '0;
      stall_mode  <= STALL_NONE;
    end else begin
      stall_phase <= stall_phase + 6'd1;
      if (stall_phase == '0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (stall_phase[2:0] >= 3'd3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // sender works in bursts; a gap is only opened at the start of a burst
  task automatic send_word(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                           input logic [DATA_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_port    <= port;
    in_time_us <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    op_words[int'(op)]++;
  endtask

  // mostly a forward-running clock, with backward steps, jumps and extremes
  function automatic logic [DATA_W-1:0] next_time();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      now_us = now_us + 64'($urandom_range(0, 5000));
    end else if (pick < 70) begin
      return now_us - 64'($urandom_range(1, 5000));
    end else if (pick < 78) begin
      now_us = {$urandom, $urandom};
    end else if (pick < 86) begin
      return {$urandom, $urandom};
    end else if (pick < 90) begin
      return '0;
    end else if (pick < 95) begin
      case ($urandom_range(0, 3))
        0:       return 64'h8000_0000_0000_0000;
        1:       return 64'h7fff_ffff_ffff_ffff;
        2:       return '1;
        default: return 64'd1;
      endcase
    end else begin
      now_us = 64'($urandom_range(1, 100));
    end
    return now_us;
  endfunction

  initial begin
    int unsigned sel;
    logic [OP_W-1:0]   op;
    logic [PORT_W-1:0] port;
    int directed_words;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_word(OP_REPORT,    5'd0,  64'd0);                 // all zero, no word out
    send_word(OP_POLL,      5'd31, 64'd100);               // invalid port
    send_word(OP_POLL,      5'd0,  64'd200);               // never stamped
    send_word(OP_STAMP_ONE, 5'd0,  64'd0);                 // stamp of zero reads as never
    send_word(OP_POLL,      5'd0,  64'd300);
    send_word(OP_STAMP_ONE, 5'd1,  64'd1000);
    send_word(OP_POLL,      5'd1,  64'd500);               // clock went backwards
    send_word(OP_POLL,      5'd1,  64'd1700);
    send_word(OP_STAMP_ONE, 5'd20, 64'd7);                 // invalid port, still counted
    send_word(OP_REPORT,    5'd17, 64'h5555_aaaa_5555_aaaa);
    send_word(OP_REPORT,    5'd0,  64'd0);                 // just cleared
    send_word(OP_STAMP_ALL, 5'd31, 64'h8000_0000_0000_0000);
    send_word(OP_POLL,      5'd3,  64'h7fff_ffff_ffff_ffff); // largest possible latency
    send_word(OP_POLL,      5'd2,  64'h7fff_ffff_ffff_ffff); // total wraps
    send_word(OP_STAMP_ALL, 5'd0,  '1);
    send_word(OP_POLL,      5'd0,  '1);                    // zero latency
    send_word(OP_POLL,      5'd3,  64'd0);
    send_word(OP_REPORT,    5'd31, '1);
    send_word(OP_STAMP_ONE, 5'd3,  64'd1);
    send_word(OP_REPORT,    5'd5,  64'd0);                 // update count only
    send_word(OP_STAMP_ONE, 5'd2,  64'h7fff_ffff_ffff_ffff);
    send_word(OP_POLL,      5'd2,  64'h8000_0000_0000_0000); // signed compare says earlier
    send_word(OP_REPORT,    5'd0,  64'd0);
    directed_words = words_sent;

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30)      op = OP_STAMP_ONE;
      else if (sel < 40) op = OP_STAMP_ALL;
      else if (sel < 85) op = OP_POLL;
      else               op = OP_REPORT;
      if ($urandom_range(0, 4) == 0) port = 5'($urandom_range(0, 31));
      else                           port = 5'($urandom_range(0, NUM_PORTS - 1));
      send_word(op, port, next_time());
    end
    in_valid <= 1'b0;

    // let the checker take the last word before looking at its queue
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words (%0d directed): %0d stamp-one, %0d stamp-all,",
             words_sent, directed_words, op_words[0], op_words[1]);
    $display("%0d poll, %0d report; compared %0d report words, %0d mismatches",
             op_words[2], op_words[3], reports_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
